// ----- rtl/core/mbrot_pkg.sv -----
// Shared types, register indexes and fixed-point constants for the Mandelbrot pixel core.
`default_nettype none
package mbrot_pkg;

  localparam int FRACTION_BITS = 26;
  localparam int IMAGE_SIZE = 1024;

  localparam int COORD_WIDTH = 10;
  localparam int STEP_WIDTH = 27;
  localparam int ORIGIN_WIDTH = 29;
  localparam int LIMIT_WIDTH = 29;
  localparam int COUNT_WIDTH = 10;
  localparam int CFG_DATA_WIDTH = 29;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int OPND_WIDTH = 32;
  localparam int PROD_WIDTH = 2 * OPND_WIDTH;
  localparam int Z_WIDTH = 39;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLUMN_STEP = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_STEP = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REAL_ORIGIN = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAG_ORIGIN = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ESCAPE_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITERATION_CAP = 3'd5;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [STEP_WIDTH-1:0] step_t;
  typedef logic signed [ORIGIN_WIDTH-1:0] origin_t;
  typedef logic [LIMIT_WIDTH-1:0] limit_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [OPND_WIDTH-1:0] opnd_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [Z_WIDTH-1:0] z_t;

  localparam step_t RESET_COLUMN_STEP = 27'd1078535;
  localparam step_t RESET_ROW_STEP = 27'd1078535;
  localparam origin_t RESET_REAL_ORIGIN = -29'sd110729626;
  localparam origin_t RESET_IMAG_ORIGIN = -29'sd74490839;
  localparam limit_t RESET_ESCAPE_LIMIT = 29'd150994944;
  localparam count_t RESET_ITERATION_CAP = 10'd100;

  typedef struct packed {
    step_t   column_step;
    step_t   row_step;
    origin_t real_origin;
    origin_t imag_origin;
    limit_t  escape_limit;
    count_t  iteration_cap;
  } cfg_t;

  typedef struct packed {
    opnd_t a0;
    opnd_t b0;
    opnd_t a1;
    opnd_t b1;
    opnd_t a2;
    opnd_t b2;
  } mul_ops_t;

endpackage
`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time_pixel_core.sv -----
// Top level of the Mandelbrot escape-time pixel core: sequencer and iteration datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    pixel_column, pixel_row
//   result    out        out_valid / out_stall  shade, iteration_count
//   config    in         config_write           config_index, config_data
//
// A pixel runs from its transaction through an origin step and its iterations to its
// result, and the core returns to idle before it accepts the next pixel; each iteration
// is one pass through the multiplier bank followed by one evaluate step.
// Reset is synchronous and restores the state, out_valid and the config registers to their defaults.
// A result waits in the output register while the next pixel is accepted and iterated.
// A stalled output holds the core in its evaluate step once the next result is ready.
`default_nettype none
module mandelbrot_escape_time_pixel_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [mbrot_pkg::COORD_WIDTH-1:0]     pixel_column,
  input  wire logic [mbrot_pkg::COORD_WIDTH-1:0]     pixel_row,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [7:0]                                  shade,
  output logic [mbrot_pkg::COUNT_WIDTH-1:0]          iteration_count,
  input  wire logic                                   config_write,
  input  wire logic [mbrot_pkg::CFG_INDEX_WIDTH-1:0] config_index,
  input  wire logic [mbrot_pkg::CFG_DATA_WIDTH-1:0]  config_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ORIGIN = 2'd1;
  localparam logic [1:0] ST_MUL = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  localparam logic [7:0] SHADE_MODULUS = 8'd255;
  localparam mbrot_pkg::z_t Z_LIM = mbrot_pkg::z_t'((64'sd1 <<< 31) - 64'sd1);

  logic [1:0] state;
  mbrot_pkg::cfg_t cfg;
  mbrot_pkg::mul_ops_t ops;
  mbrot_pkg::prod_t p0;
  mbrot_pkg::prod_t p1;
  mbrot_pkg::prod_t p2;
  mbrot_pkg::z_t zx;
  mbrot_pkg::z_t zy;
  mbrot_pkg::z_t c_re;
  mbrot_pkg::z_t c_im;
  mbrot_pkg::z_t nx;
  mbrot_pkg::z_t ny;
  mbrot_pkg::count_t count;
  mbrot_pkg::coord_t col_wrapped;
  mbrot_pkg::coord_t row_wrapped;
  mbrot_pkg::opnd_t zx_op;
  mbrot_pkg::opnd_t zy_op;
  logic [63:0] mag_sum;
  logic in_bound;
  logic below_limit;
  logic keep_going;
  logic result_room;
  logic accept;
  logic mul_load;
  logic finish;
  logic [15:0] count_sq;
  logic [7:0] shade_next;

  mbrot_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .cfg          (cfg)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign col_wrapped = mbrot_pkg::coord_t'(pixel_column % mbrot_pkg::IMAGE_SIZE);
  assign row_wrapped = mbrot_pkg::coord_t'(pixel_row % mbrot_pkg::IMAGE_SIZE);
  assign zx_op = mbrot_pkg::opnd_t'(zx);
  assign zy_op = mbrot_pkg::opnd_t'(zy);

  always_comb begin
    if (state == ST_IDLE) begin
      ops.a0 = mbrot_pkg::opnd_t'(col_wrapped);
      ops.b0 = mbrot_pkg::opnd_t'(cfg.column_step);
      ops.a1 = mbrot_pkg::opnd_t'(row_wrapped);
      ops.b1 = mbrot_pkg::opnd_t'(cfg.row_step);
    end else begin
      ops.a0 = zx_op;
      ops.b0 = zx_op;
      ops.a1 = zy_op;
      ops.b1 = zy_op;
    end
    ops.a2 = zx_op;
    ops.b2 = zy_op;
  end

  assign mul_load = accept || (state == ST_MUL);

  mbrot_mul_unit u_mul (
    .clk  (clk),
    .load (mul_load),
    .ops  (ops),
    .p0   (p0),
    .p1   (p1),
    .p2   (p2)
  );

  // Products are only meaningful while both parts stay inside the 32-bit operand range.
  assign in_bound = (zx <= Z_LIM) && (zx >= -Z_LIM) && (zy <= Z_LIM) && (zy >= -Z_LIM);
  assign mag_sum = $unsigned(p0) + $unsigned(p1);
  assign below_limit = (mag_sum >> mbrot_pkg::FRACTION_BITS) < 64'(cfg.escape_limit);
  assign keep_going = (count < cfg.iteration_cap) && in_bound && below_limit;
  assign result_room = !out_valid || !out_stall;
  assign finish = (state == ST_EVAL) && !keep_going && result_room;

  assign nx = mbrot_pkg::z_t'((p0 - p1) >>> mbrot_pkg::FRACTION_BITS) + c_re;
  assign ny = mbrot_pkg::z_t'(p2 >>> (mbrot_pkg::FRACTION_BITS - 1)) + c_im;

  assign count_sq = count[7:0] * count[7:0];
  assign shade_next = (count_sq[7:0] == SHADE_MODULUS) ? 8'd0 : count_sq[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ORIGIN;
          end
        end
        ST_ORIGIN: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (keep_going) begin
            state <= ST_MUL;
          end else if (result_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ORIGIN) begin
      c_re <= mbrot_pkg::z_t'(cfg.real_origin) + mbrot_pkg::z_t'(p0);
      c_im <= mbrot_pkg::z_t'(cfg.imag_origin) + mbrot_pkg::z_t'(p1);
      zx <= '0;
      zy <= '0;
      count <= '0;
    end else if ((state == ST_EVAL) && keep_going) begin
      zx <= nx;
      zy <= ny;
      count <= count + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      shade <= shade_next;
      iteration_count <= count;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_origin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_ORIGIN))
    else $error("accepted pixel did not start its origin step");

  a_iterate_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> ($stable(zx) && $stable(zy) && $stable(count)))
    else $error("iteration state moved between multiply and evaluate");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EVAL))
    else $error("result transaction raised outside the evaluate step");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/mbrot_cfg_regs.sv -----
// Configuration register file for the Mandelbrot pixel core.
`default_nettype none
module mbrot_cfg_regs (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   config_write,
  input  wire logic [mbrot_pkg::CFG_INDEX_WIDTH-1:0] config_index,
  input  wire logic [mbrot_pkg::CFG_DATA_WIDTH-1:0]  config_data,
  output mbrot_pkg::cfg_t                             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_step <= mbrot_pkg::RESET_COLUMN_STEP;
      cfg.row_step <= mbrot_pkg::RESET_ROW_STEP;
      cfg.real_origin <= mbrot_pkg::RESET_REAL_ORIGIN;
      cfg.imag_origin <= mbrot_pkg::RESET_IMAG_ORIGIN;
      cfg.escape_limit <= mbrot_pkg::RESET_ESCAPE_LIMIT;
      cfg.iteration_cap <= mbrot_pkg::RESET_ITERATION_CAP;
    end else if (config_write) begin
      unique case (config_index)
        mbrot_pkg::CFG_COLUMN_STEP: begin
          cfg.column_step <= config_data[mbrot_pkg::STEP_WIDTH-1:0];
        end
        mbrot_pkg::CFG_ROW_STEP: begin
          cfg.row_step <= config_data[mbrot_pkg::STEP_WIDTH-1:0];
        end
        mbrot_pkg::CFG_REAL_ORIGIN: begin
          cfg.real_origin <= mbrot_pkg::origin_t'(config_data[mbrot_pkg::ORIGIN_WIDTH-1:0]);
        end
        mbrot_pkg::CFG_IMAG_ORIGIN: begin
          cfg.imag_origin <= mbrot_pkg::origin_t'(config_data[mbrot_pkg::ORIGIN_WIDTH-1:0]);
        end
        mbrot_pkg::CFG_ESCAPE_LIMIT: begin
          cfg.escape_limit <= config_data[mbrot_pkg::LIMIT_WIDTH-1:0];
        end
        mbrot_pkg::CFG_ITERATION_CAP: begin
          cfg.iteration_cap <= config_data[mbrot_pkg::COUNT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mbrot_mul_unit.sv -----
// Shared multiplier bank: three signed 32 by 32 products, registered.
`default_nettype none
module mbrot_mul_unit (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire mbrot_pkg::mul_ops_t ops,
  output mbrot_pkg::prod_t        p0,
  output mbrot_pkg::prod_t        p1,
  output mbrot_pkg::prod_t        p2
);

  always_ff @(posedge clk) begin
    if (load) begin
      p0 <= ops.a0 * ops.b0;
      p1 <= ops.a1 * ops.b1;
      p2 <= ops.a2 * ops.b2;
    end
  end

endmodule
`default_nettype wire

// ----- tb/mbrot_pixel_checker.sv -----
// Checker for the Mandelbrot pixel core: mirrors its registers, predicts every result and compares.
`timescale 1ns / 100ps
module mbrot_pixel_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_stall,
  input  wire logic [mbrot_pkg::COORD_WIDTH-1:0]     pixel_column,
  input  wire logic [mbrot_pkg::COORD_WIDTH-1:0]     pixel_row,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_stall,
  input  wire logic [7:0]                             shade,
  input  wire logic [mbrot_pkg::COUNT_WIDTH-1:0]     iteration_count,
  input  wire logic                                   config_write,
  input  wire logic [mbrot_pkg::CFG_INDEX_WIDTH-1:0] config_index,
  input  wire logic [mbrot_pkg::CFG_DATA_WIDTH-1:0]  config_data,
  output int                                          fail_count,
  output int                                          owed_count
);
  import mbrot_pkg::*;

  typedef struct packed {
    logic [7:0] shade;
    count_t     count;
  } pixel_result_t;

  step_t   col_pitch;
  step_t   row_pitch;
  origin_t re_base;
  origin_t im_base;
  limit_t  bailout;
  count_t  iter_ceiling;

  pixel_result_t owed_results[$];
  int failures;

  function automatic bit below_bailout(longint zx, longint zy);
    longint bound;
    longint unsigned ax, ay, mag;
    bound = longint'(1) << 31;
    if (zx >= bound || zx <= -bound || zy >= bound || zy <= -bound) return 1'b0;
    ax = (zx < 0) ? -zx : zx;
    ay = (zy < 0) ? -zy : zy;
    mag = ax * ax + ay * ay;
    return (mag >> FRACTION_BITS) < longint'(bailout);
  endfunction

  function automatic pixel_result_t predict_pixel(coord_t col, coord_t row);
    longint col_l, row_l, cs_l, rs_l;
    longint c_re, c_im, zx, zy, nx;
    int n;
    pixel_result_t r;
    col_l = longint'(col);
    row_l = longint'(row);
    cs_l = longint'(col_pitch);
    rs_l = longint'(row_pitch);
    c_re = longint'(re_base) + col_l * cs_l;
    c_im = longint'(im_base) + row_l * rs_l;
    zx = 0;
    zy = 0;
    n = 0;
    while (n < int'(iter_ceiling) && below_bailout(zx, zy)) begin
      nx = ((zx * zx - zy * zy) >>> FRACTION_BITS) + c_re;
      zy = ((zx * zy) >>> (FRACTION_BITS - 1)) + c_im;
      zx = nx;
      n++;
    end
    r.count = count_t'(n);
    r.shade = 8'(((n * n) % 256) % 255);
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      col_pitch = RESET_COLUMN_STEP;
      row_pitch = RESET_ROW_STEP;
      re_base = RESET_REAL_ORIGIN;
      im_base = RESET_IMAG_ORIGIN;
      bailout = RESET_ESCAPE_LIMIT;
      iter_ceiling = RESET_ITERATION_CAP;
      owed_results.delete();
      failures = 0;
    end else begin
      if (config_write) begin
        case (config_index)
          CFG_COLUMN_STEP:   col_pitch = config_data[STEP_WIDTH-1:0];
          CFG_ROW_STEP:      row_pitch = config_data[STEP_WIDTH-1:0];
          CFG_REAL_ORIGIN:   re_base = config_data[ORIGIN_WIDTH-1:0];
          CFG_IMAG_ORIGIN:   im_base = config_data[ORIGIN_WIDTH-1:0];
          CFG_ESCAPE_LIMIT:  bailout = config_data[LIMIT_WIDTH-1:0];
          CFG_ITERATION_CAP: iter_ceiling = config_data[COUNT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no pixel outstanding: shade %0d, iteration_count %0d",
                 shade, iteration_count);
          failures++;
        end else begin
          want = owed_results.pop_front();
          if (shade !== want.shade) begin
            $error("shade: expected %0d, actual %0d", want.shade, shade);
            failures++;
          end
          if (iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, actual %0d", want.count, iteration_count);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(predict_pixel(pixel_column, pixel_row));
    end
    fail_count <= failures;
    owed_count <= owed_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the Mandelbrot pixel core: clock, reset, register settings and pixel stimulus.
`timescale 1ns / 100ps
module tb_top;
  import mbrot_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PIXELS_PER_MODE = 550;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t pixel_column = '0;
  coord_t pixel_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] shade;
  count_t iteration_count;
  logic config_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] config_index = '0;
  logic [CFG_DATA_WIDTH-1:0] config_data = '0;

  int fail_count;
  int owed_count;
  int send_gap_pct = 17;
  int recv_stall_pct = 53;
  int cycle_count = 0;
  int pixels_sent = 0;
  int settings_applied = 0;
  int deep_settings = 0;

  mandelbrot_escape_time_pixel_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_column(pixel_column), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .shade(shade), .iteration_count(iteration_count),
    .config_write(config_write), .config_index(config_index), .config_data(config_data)
  );

  mbrot_pixel_checker pixel_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_column(pixel_column), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .shade(shade), .iteration_count(iteration_count),
    .config_write(config_write), .config_index(config_index), .config_data(config_data),
    .fail_count(fail_count), .owed_count(owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mandelbrot_escape_time_pixel_core regression: fail");
    $finish;
  end

  task automatic send_pixel(input coord_t col, input coord_t row);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_column <= col;
    pixel_row <= row;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    logic [CFG_DATA_WIDTH-1:0] word;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    int n;
    settings_applied++;
    if (s.iteration_cap > 400) deep_settings++;
    config_write <= 1'b1;
    for (n = 0; n < (1 << CFG_INDEX_WIDTH); n++) begin
      idx = CFG_INDEX_WIDTH'(n);
      word = CFG_DATA_WIDTH'($urandom);
      case (idx)
        CFG_COLUMN_STEP:   word[STEP_WIDTH-1:0] = s.column_step;
        CFG_ROW_STEP:      word[STEP_WIDTH-1:0] = s.row_step;
        CFG_REAL_ORIGIN:   word = s.real_origin;
        CFG_IMAG_ORIGIN:   word = s.imag_origin;
        CFG_ESCAPE_LIMIT:  word = s.escape_limit;
        CFG_ITERATION_CAP: word[COUNT_WIDTH-1:0] = s.iteration_cap;
        default: begin
        end
      endcase
      config_index <= idx;
      config_data <= word;
      @(posedge clk);
    end
    config_write <= 1'b0;
  endtask

  function automatic cfg_t reset_settings();
    cfg_t s;
    s.column_step = RESET_COLUMN_STEP;
    s.row_step = RESET_ROW_STEP;
    s.real_origin = RESET_REAL_ORIGIN;
    s.imag_origin = RESET_IMAG_ORIGIN;
    s.escape_limit = RESET_ESCAPE_LIMIT;
    s.iteration_cap = RESET_ITERATION_CAP;
    return s;
  endfunction

  function automatic step_t draw_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return step_t'($urandom_range(1 << 10, 1 << 19));
    if (pick < 85) return step_t'($urandom);
    return step_t'($urandom_range(0, 1023));
  endfunction

  function automatic origin_t draw_origin(int lowest);
    if ($urandom_range(0, 99) < 60) return origin_t'($urandom_range(0, 3 << 26) + lowest);
    return origin_t'($urandom);
  endfunction

  function automatic cfg_t draw_settings();
    cfg_t s;
    int pick;
    s.column_step = draw_step();
    s.row_step = draw_step();
    s.real_origin = draw_origin(-(2 << 26));
    s.imag_origin = draw_origin(-(3 << 25));
    pick = $urandom_range(0, 99);
    if (pick < 50) s.escape_limit = limit_t'(1 << 28);
    else if (pick < 80) s.escape_limit = limit_t'($urandom);
    else s.escape_limit = limit_t'($urandom_range(0, 1 << 26));
    pick = $urandom_range(0, 99);
    if (pick < 5) s.iteration_cap = '0;
    else if (pick < 70) s.iteration_cap = count_t'($urandom_range(1, 100));
    else if (pick < 90) s.iteration_cap = count_t'($urandom_range(101, 400));
    else s.iteration_cap = '1;
    return s;
  endfunction

  initial begin
    cfg_t s;
    coord_t col, row;
    int mode, sent_in_mode, batch;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'h155, 10'h2AA);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'd100, 10'd70);
    send_pixel(10'd60, 10'd69);
    send_pixel(10'd512, 10'd512);
    wait_for_results();

    // A cap of zero runs no iteration at all.
    s = reset_settings();
    s.iteration_cap = '0;
    apply_settings(s);
    send_pixel(10'd100, 10'd70);
    send_pixel(10'd700, 10'd500);
    wait_for_results();

    // Nothing lies below an escape limit of zero.
    s.iteration_cap = RESET_ITERATION_CAP;
    s.escape_limit = '0;
    apply_settings(s);
    send_pixel(10'd100, 10'd70);
    send_pixel(10'd0, 10'd0);
    wait_for_results();

    // Largest steps and extreme origins push z past the 32-bit operand range bound.
    s.column_step = '1;
    s.row_step = '1;
    s.real_origin = 29'sh0FFF_FFFF;
    s.imag_origin = 29'sh1000_0000;
    s.escape_limit = '1;
    s.iteration_cap = '1;
    apply_settings(s);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    wait_for_results();

    // With c at zero every pixel runs to the cap, and a count of 16 gives a black shade.
    s = reset_settings();
    s.column_step = '0;
    s.row_step = '0;
    s.real_origin = '0;
    s.imag_origin = '0;
    s.iteration_cap = 10'd16;
    apply_settings(s);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_for_results();

    s = reset_settings();
    s.escape_limit = limit_t'(1 << 28);
    s.iteration_cap = '1;
    apply_settings(s);
    send_pixel(10'd100, 10'd70);
    send_pixel(10'd60, 10'd69);
    send_pixel(10'd0, 10'd0);
    wait_for_results();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_gap_pct <= 17;
          recv_stall_pct <= 53;
        end
        1: begin
          send_gap_pct <= 53;
          recv_stall_pct <= 17;
        end
        default: begin
          send_gap_pct <= 0;
          recv_stall_pct <= 0;
        end
      endcase
      sent_in_mode = 0;
      while (sent_in_mode < PIXELS_PER_MODE) begin
        s = draw_settings();
        apply_settings(s);
        batch = (s.iteration_cap > 400) ? 12 : $urandom_range(60, 140);
        if (batch > PIXELS_PER_MODE - sent_in_mode) batch = PIXELS_PER_MODE - sent_in_mode;
        repeat (batch) begin
          if ($urandom_range(0, 99) < 15) col = $urandom_range(0, 1) ? '0 : '1;
          else col = coord_t'($urandom_range(0, 1023));
          if ($urandom_range(0, 99) < 15) row = $urandom_range(0, 1) ? '0 : '1;
          else row = coord_t'($urandom_range(0, 1023));
          send_pixel(col, row);
          sent_in_mode++;
        end
        wait_for_results();
      end
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d pixels through %0d register settings, %0d of them with caps above 400,",
             pixels_sent, settings_applied, deep_settings);
    $display("with the input and result channels idling in three different patterns.");
    if (fail_count == 0)
      $display("mandelbrot_escape_time_pixel_core regression: pass");
    else
      $display("mandelbrot_escape_time_pixel_core regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mbrot_pkg.sv
rtl/core/mbrot_cfg_regs.sv
rtl/core/mbrot_mul_unit.sv
rtl/core/mandelbrot_escape_time_pixel_core.sv
tb/mbrot_pixel_checker.sv
tb/tb_top.sv
